### hdl/assert_macros.svh
// Assertion macros used by the SM3 controller (sm3_ctrl).
// No dependencies; each macro compiles to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

### hdl/sm3_pkg.sv
// Shared types, constants and helper functions of the SM3 hash engine.
// No dependencies; used by sm3_ctrl, sm3_dp and sm3_hash_engine.
package sm3_pkg;

   localparam logic [31:0] SM3_IV [8] = '{
      32'h7380_166F, 32'h4914_B2B9, 32'h1724_42D7, 32'hDA8A_0600,
      32'hA96F_30BC, 32'h1631_38AA, 32'hE38D_EE4D, 32'hB0FB_0E4E
   };

   localparam logic [31:0] T_LOW    = 32'h79CC_4519;
   localparam logic [31:0] T_HIGH   = 32'h7A87_9D8A;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   localparam logic [5:0]  ROUND_LAST = 6'd63;
   localparam logic [3:0]  FILL_TOP   = 4'd15;
   localparam logic [3:0]  LEN_SLOT   = 4'd14;
   localparam logic [2:0]  IDX_LAST   = 3'd7;

   // source of a word pushed into the block buffer
   localparam logic [2:0] SRC_INPUT  = 3'd0;
   localparam logic [2:0] SRC_MARK   = 3'd1;
   localparam logic [2:0] SRC_ZERO   = 3'd2;
   localparam logic [2:0] SRC_LEN_HI = 3'd3;
   localparam logic [2:0] SRC_LEN_LO = 3'd4;

   typedef struct packed {
      logic       push;
      logic [2:0] push_sel;
      logic       load_work;
      logic       round;
      logic [5:0] round_idx;
      logic       fold;
      logic       shift_out;
      logic       restart;
   } cmd_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] tmp;
      tmp = {x, x} << n;
      return tmp[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
   endfunction

   // round constant, rotated by the round number mod 32
   function automatic logic [31:0] t_const(input logic [5:0] r);
      logic [31:0] t;
      t = (r < 6'd16) ? T_LOW : T_HIGH;
      return rotl32(t, r[4:0]);
   endfunction

   // final message word: keep the valid bytes and, if fewer than four, append the marker byte
   function automatic logic [31:0] pad_word(input logic [31:0] word, input logic [2:0] cnt);
      logic [31:0] res;
      unique case (cnt)
         3'd0: res = {PAD_BYTE, 24'h0};
         3'd1: res = {word[31:24], PAD_BYTE, 16'h0};
         3'd2: res = {word[31:16], PAD_BYTE, 8'h0};
         3'd3: res = {word[31:8], PAD_BYTE};
         default: res = word;
      endcase
      return res;
   endfunction

endpackage

### hdl/sm3_dp.sv
// SM3 datapath: block buffer as a message-schedule shift line, round unit,
// chaining value and bit length. Depends on sm3_pkg; driven by sm3_ctrl.
module sm3_dp
   import sm3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [31:0] req_message_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_word,
   output logic [31:0] rsp_digest_word
);

   logic [31:0] sched_ff [16];
   logic [31:0] sched_in [16];
   logic [31:0] work_ff  [8];
   logic [31:0] work_in  [8];
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [63:0] len_ff;
   logic [63:0] len_in;

   logic [31:0] push_word;
   logic [31:0] w_new;
   logic [31:0] rnd [8];
   logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2;
   logic [2:0]  cnt_clamp;
   logic [5:0]  len_inc;

   // word to push
   always_comb begin
      unique case (cmd.push_sel)
         SRC_INPUT:  push_word = req_last_word ? pad_word(req_message_word, req_byte_count)
                                               : req_message_word;
         SRC_MARK:   push_word = {PAD_BYTE, 24'h0};
         SRC_ZERO:   push_word = '0;
         SRC_LEN_HI: push_word = len_ff[63:32];
         SRC_LEN_LO: push_word = len_ff[31:0];
         default:    push_word = '0;
      endcase
   end

   // expansion: sched_ff[k] holds w[r+k] during round r
   assign w_new = perm1(sched_ff[0] ^ sched_ff[7] ^ rotl32(sched_ff[13], 5'd15))
                ^ rotl32(sched_ff[3], 5'd7) ^ sched_ff[10];

   // one compression round
   always_comb begin
      a12 = rotl32(work_ff[0], 5'd12);
      ss1 = rotl32(a12 + work_ff[4] + t_const(cmd.round_idx), 5'd7);
      ss2 = ss1 ^ a12;
      if (cmd.round_idx < 6'd16) begin
         ffv = work_ff[0] ^ work_ff[1] ^ work_ff[2];
         ggv = work_ff[4] ^ work_ff[5] ^ work_ff[6];
      end else begin
         ffv = (work_ff[0] & work_ff[1]) | (work_ff[0] & work_ff[2])
             | (work_ff[1] & work_ff[2]);
         ggv = (work_ff[4] & work_ff[5]) | (~work_ff[4] & work_ff[6]);
      end
      tt1 = ffv + work_ff[3] + ss2 + (sched_ff[0] ^ sched_ff[4]);
      tt2 = ggv + work_ff[7] + ss1 + sched_ff[0];
      rnd[0] = tt1;
      rnd[1] = work_ff[0];
      rnd[2] = rotl32(work_ff[1], 5'd9);
      rnd[3] = work_ff[2];
      rnd[4] = perm0(tt2);
      rnd[5] = work_ff[4];
      rnd[6] = rotl32(work_ff[5], 5'd19);
      rnd[7] = work_ff[6];
   end

   always_comb begin
      sched_in = sched_ff;
      if (cmd.push || cmd.round) begin
         for (int i = 0; i < 15; i++) begin
            sched_in[i] = sched_ff[i + 1];
         end
         sched_in[15] = cmd.push ? push_word : w_new;
      end
   end

   always_comb begin
      work_in = work_ff;
      if (cmd.load_work) begin
         work_in = chain_ff;
      end else if (cmd.round) begin
         work_in = rnd;
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (cmd.restart) begin
         chain_in = SM3_IV;
      end else if (cmd.fold) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] ^ rnd[i];
         end
      end else if (cmd.shift_out) begin
         for (int i = 0; i < 7; i++) begin
            chain_in[i] = chain_ff[i + 1];
         end
         chain_in[7] = chain_ff[0];
      end
   end

   always_comb begin
      cnt_clamp = req_byte_count[2] ? 3'd4 : req_byte_count;
      len_inc   = req_last_word ? {cnt_clamp, 3'b000} : 6'd32;
      len_in    = len_ff;
      if (cmd.restart) begin
         len_in = '0;
      end else if (cmd.push && cmd.push_sel == SRC_INPUT) begin
         len_in = len_ff + 64'(len_inc);
      end
   end

   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
      work_ff  <= work_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= SM3_IV;
         len_ff   <= '0;
      end else begin
         chain_ff <= chain_in;
         len_ff   <= len_in;
      end
   end

   assign rsp_digest_word = chain_ff[0];

endmodule

### hdl/sm3_ctrl.sv
// SM3 controller: accepts message beats, sequences padding, the 64 rounds
// and the digest beats. Depends on sm3_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sm3_ctrl
   import sm3_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [2:0] req_byte_count,
   input  logic       req_last_word,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_word_index,
   output logic       rsp_digest_last,
   output cmd_type    cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PAD   = 2'd1;
   localparam logic [1:0] S_ROUND = 2'd2;
   localparam logic [1:0] S_OUT   = 2'd3;

   localparam logic [1:0] PH_MARK   = 2'd0;
   localparam logic [1:0] PH_ZERO   = 2'd1;
   localparam logic [1:0] PH_LEN_LO = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [3:0] fill_ff,  fill_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] idx_ff,   idx_in;
   logic       pad_ff,   pad_in;

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_OUT);
   assign rsp_word_index  = idx_ff;
   assign rsp_digest_last = (idx_ff == IDX_LAST);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      fill_in  = fill_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      pad_in   = pad_ff;
      cmd           = '0;
      cmd.round_idx = round_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.push     = 1'b1;
               cmd.push_sel = SRC_INPUT;
               fill_in      = fill_ff + 4'd1;
               pad_in       = req_last_word;
               phase_in     = req_byte_count[2] ? PH_MARK : PH_ZERO;
               if (fill_ff == FILL_TOP) begin
                  cmd.load_work = 1'b1;
                  state_in      = S_ROUND;
               end else if (req_last_word) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            cmd.push = 1'b1;
            unique case (phase_ff)
               PH_MARK: begin
                  cmd.push_sel = SRC_MARK;
                  phase_in     = PH_ZERO;
               end
               PH_ZERO: begin
                  if (fill_ff == LEN_SLOT) begin
                     cmd.push_sel = SRC_LEN_HI;
                     phase_in     = PH_LEN_LO;
                  end else begin
                     cmd.push_sel = SRC_ZERO;
                  end
               end
               PH_LEN_LO: begin
                  cmd.push_sel = SRC_LEN_LO;
                  phase_in     = PH_DONE;
               end
               PH_DONE: begin
                  cmd.push = 1'b0;
               end
            endcase
            if (cmd.push) begin
               fill_in = fill_ff + 4'd1;
               if (fill_ff == FILL_TOP) begin
                  cmd.load_work = 1'b1;
                  state_in      = S_ROUND;
               end
            end
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            round_in  = round_ff + 6'd1;
            if (round_ff == ROUND_LAST) begin
               cmd.fold = 1'b1;
               if (!pad_ff) begin
                  state_in = S_IDLE;
               end else if (phase_ff == PH_DONE) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_PAD;
               end
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               cmd.shift_out = 1'b1;
               idx_in        = idx_ff + 3'd1;
               if (idx_ff == IDX_LAST) begin
                  cmd.restart = 1'b1;
                  pad_in      = 1'b0;
                  state_in    = S_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_MARK;
         fill_ff  <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
         pad_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         pad_ff   <= pad_in;
      end
   end

   `ASSERT_PROP(a_round_runs_full, clock, reset, (state_ff == S_ROUND && round_ff != ROUND_LAST) |=> (state_ff == S_ROUND), "compression left before the last round")
   `ASSERT_PROP(a_out_block_empty, clock, reset, (state_ff == S_OUT) |-> (fill_ff == '0 && pad_ff), "digest shown with a partial block")
   `ASSERT_PROP(a_idle_after_digest, clock, reset, (rsp_valid && !rsp_stall && rsp_digest_last) |=> (state_ff == S_IDLE && !pad_ff && idx_ff == '0), "no return to idle after digest")
   `ASSERT_NEVER(a_done_block_empty, clock, reset, pad_ff && phase_ff == PH_DONE && fill_ff != '0, "length written but block not full")

endmodule

### hdl/sm3_hash_engine.sv
// Top level of the SM3 hash engine: controller plus datapath.
// Depends on sm3_pkg, sm3_ctrl and sm3_dp.

// SM3 (256-bit digest) of a byte message given as big-endian 32-bit beats.
// A beat is taken while the block is idle; every sixteenth beat starts a
// compression, one round per cycle on a single round unit, during which
// req_stall is high. The last beat adds one padding beat per cycle up to
// the end of the block (at most 16), one or two compressions, then eight
// digest beats on rsp_, word 0 first, one per cycle unless stalled. After
// the eighth digest beat the next message may start at once; no clearing
// pass is needed after reset.
module sm3_hash_engine
   import sm3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_message_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_digest_last
);

   cmd_type cmd;

   sm3_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_byte_count  (req_byte_count),
      .req_last_word   (req_last_word),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_word_index  (rsp_word_index),
      .rsp_digest_last (rsp_digest_last),
      .cmd             (cmd)
   );

   sm3_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_message_word (req_message_word),
      .req_byte_count   (req_byte_count),
      .req_last_word    (req_last_word),
      .rsp_digest_word  (rsp_digest_word)
   );

endmodule
